>>> hw/rtl/lspr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip pattern renderer - shared package
// Field widths, pattern codes, wave and reciprocal constants, the structs
// passed between the frame, sequencer and pixel stages, and small helpers.
// ----------------------------------------------------------------------------
package lspr_pkg;

  // Strip size and field widths
  localparam int LED_COUNT = 16;
  localparam int PIX_W     = 6;
  localparam int COL_W     = 8;
  localparam int PAT_W     = 3;
  localparam int FRAME_W   = 32;
  localparam int HUE_W     = 9;

  // Pattern codes; every code from rainbow upwards is rainbow
  localparam logic [PAT_W-1:0] PAT_SOLID   = 3'd0;
  localparam logic [PAT_W-1:0] PAT_BREATH  = 3'd1;
  localparam logic [PAT_W-1:0] PAT_CHASE   = 3'd2;
  localparam logic [PAT_W-1:0] PAT_PULSE   = 3'd3;
  localparam logic [PAT_W-1:0] PAT_RAINBOW = 3'd4;

  localparam logic [COL_W-1:0] BRIGHT_RESET = 8'd128;

  // Triangle waves: breath period 80 (16 x 5), pulse period 28 (4 x 7)
  localparam int BREATH_HALF  = 40;
  localparam int BREATH_FLOOR = 24;
  localparam int PULSE_HALF   = 14;
  localparam int PULSE_FLOOR  = 16;

  // Hue circle
  localparam int HUE_FULL   = 360;
  localparam int HUE_SECTOR = 60;
  localparam int SHIFT_MOD  = 45;

  // Reciprocals for division by constants
  localparam int MOD5_M      = ((1 << 10) + 4) / 5;
  localparam int MOD7_M      = ((1 << 10) + 6) / 7;
  localparam int MOD45_M     = (1 << 16) / SHIFT_MOD;
  localparam int WAVE_DIV5_M = ((1 << 14) + 4) / 5;
  localparam int WAVE_DIV7_M = ((1 << 14) + 6) / 7;
  localparam int DIV10_M     = 205;

  // frame mod LED_COUNT: fold 32 -> 22 -> 17 bits, then exact reciprocal
  localparam int LED_K1 = 65536 % LED_COUNT;
  localparam int LED_K2 = 4096 % LED_COUNT;
  localparam int LED_M  = ((1 << 23) + LED_COUNT - 1) / LED_COUNT;

  localparam logic [PIX_W-1:0] LAST_IDX = PIX_W'(LED_COUNT - 1);

  // Hue sector, named after the colour at its start
  typedef enum logic [2:0] {
    SEC_RED,
    SEC_YELLOW,
    SEC_GREEN,
    SEC_CYAN,
    SEC_BLUE,
    SEC_MAGENTA
  } hue_sector_t;

  // Per-frame values handed from the frame stages to the sequencer
  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
    logic [COL_W-1:0] level;
    logic [PIX_W-1:0] active;
    logic [HUE_W-1:0] shift;
  } frame_ctx_t;

  // One LED job issued by the sequencer
  typedef struct packed {
    frame_ctx_t       ctx;
    logic [PIX_W-1:0] idx;
    logic             last;
  } pix_item_t;

  // One finished LED
  typedef struct packed {
    logic [PIX_W-1:0] idx;
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
    logic             last;
  } pix_out_t;

  // Hue offset of an LED around the strip
  function automatic logic [HUE_W-1:0] hue_offset(input logic [PIX_W-1:0] idx);
    return HUE_W'((int'(idx) * HUE_FULL) / LED_COUNT);
  endfunction

  // x / 255 rounded down, valid for x up to 255 * 255
  function automatic logic [COL_W-1:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

endpackage

>>> hw/rtl/lspr_frame_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip pattern renderer - frame stages
// Seven register stages that turn one frame request into the per-frame
// values: wave level, chase position and rainbow hue shift.
// ----------------------------------------------------------------------------
module lspr_frame_prep import lspr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [PAT_W-1:0]   pattern,
  input  logic [COL_W-1:0]   base_red,
  input  logic [COL_W-1:0]   base_green,
  input  logic [COL_W-1:0]   base_blue,
  input  logic [FRAME_W-1:0] frame_number,
  input  logic [COL_W-1:0]   brightness,
  output logic               ctx_valid,
  input  logic               ctx_stall,
  output frame_ctx_t         ctx
);

  localparam int NST = 7;

  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } req_t;

  logic [NST-1:0] vld;
  logic [NST-1:0] move;
  req_t           req [NST-1];

  // Stage 0 registers
  logic [6:0]  s0_d5;
  logic [6:0]  s0_d7;
  logic [13:0] s0_d45;
  logic [21:0] s0_dl;
  logic [3:0]  s0_lo4;
  // Stage 1 registers
  logic [6:0]  s1_d5;
  logic [6:0]  s1_d7;
  logic [4:0]  s1_q5;
  logic [3:0]  s1_q7;
  logic [12:0] s1_d45;
  logic [16:0] s1_dl;
  logic [3:0]  s1_lo4;
  // Stage 2 registers
  logic [2:0]  s2_r5;
  logic [2:0]  s2_r7;
  logic [6:0]  s2_q45;
  logic [12:0] s2_d45;
  logic [16:0] s2_ql;
  logic [16:0] s2_dl;
  logic [3:0]  s2_lo4;
  // Stage 3 registers
  logic [6:0]  s3_ph80;
  logic [4:0]  s3_ph28;
  logic [6:0]  s3_r45;
  logic [PIX_W-1:0] s3_active;
  // Stage 4 registers
  logic [HUE_W-1:0] s4_shift;
  logic [PIX_W-1:0] s4_active;
  logic             s4_rising;
  logic             s4_pulse;
  logic [13:0]      s4_prod;
  // Stage 5 registers
  logic [HUE_W-1:0] s5_shift;
  logic [PIX_W-1:0] s5_active;
  logic             s5_rising;
  logic             s5_pulse;
  logic [COL_W-1:0] s5_wq;
  // Stage 6 registers
  frame_ctx_t       s6_ctx;

  // Combinational stage values
  logic [6:0]  c0_d5;
  logic [6:0]  c0_d7;
  logic [13:0] c0_d45;
  logic [21:0] c0_dl;
  logic [14:0] c1_p5;
  logic [14:0] c1_p7;
  logic [12:0] c1_d45;
  logic [16:0] c1_dl;
  logic [6:0]  c2_t5;
  logic [6:0]  c2_t7;
  logic [23:0] c2_p45;
  logic [40:0] c2_pl;
  logic [12:0] c3_t45;
  logic [16:0] c3_tl;
  logic [6:0]  c4_r45;
  logic        c4_pulse;
  logic [6:0]  c4_ph;
  logic [6:0]  c4_half;
  logic [6:0]  c4_dist;
  logic        c4_rising;
  logic [COL_W-1:0] c4_floor;
  logic [COL_W-1:0] c4_span;
  logic [12:0] c5_op;
  logic [11:0] c5_m;
  logic [24:0] c5_pq;
  logic [COL_W-1:0] c6_floor;
  logic        c6_wave;
  logic [COL_W-1:0] c6_level;

  // Stage enables: a stage loads when empty or when the next one moves
  always_comb begin
    move[NST-1] = !vld[NST-1] || !ctx_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      move[k] = !vld[k] || move[k+1];
    end
  end

  assign req_stall = !move[0];
  assign ctx_valid = vld[NST-1];
  assign ctx       = s6_ctx;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (move[0]) begin
        vld[0] <= req_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (move[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Carry the request fields down the stages
  always_ff @(posedge clk) begin
    if (move[0]) begin
      req[0] <= '{pattern: pattern, red: base_red, green: base_green, blue: base_blue};
    end
    for (int k = 1; k < NST - 1; k++) begin
      if (move[k]) begin
        req[k] <= req[k-1];
      end
    end
  end

  // Stage 0: fold the frame number into small residue sums
  // 16 = 1 mod 5, 8 = 1 mod 7, 4096 = 1 mod 45
  always_comb begin
    c0_d5 = '0;
    for (int j = 0; j < 7; j++) begin
      c0_d5 = c0_d5 + 7'(frame_number[4 + 4*j +: 4]);
    end
    c0_d7 = '0;
    for (int j = 0; j < 10; j++) begin
      c0_d7 = c0_d7 + 7'(frame_number[2 + 3*j +: 3]);
    end
    c0_d45 = 14'(frame_number[11:0]) + 14'(frame_number[23:12])
           + 14'(frame_number[28:24]);
    c0_dl  = 22'(frame_number[31:16]) * 22'(LED_K1) + 22'(frame_number[15:0]);
  end

  always_ff @(posedge clk) begin
    if (move[0]) begin
      s0_d5  <= c0_d5;
      s0_d7  <= c0_d7;
      s0_d45 <= c0_d45;
      s0_dl  <= c0_dl;
      s0_lo4 <= frame_number[3:0];
    end
  end

  // Stage 1: quotients of the small sums, second fold
  always_comb begin
    c1_p5  = 15'(s0_d5) * 15'(MOD5_M);
    c1_p7  = 15'(s0_d7) * 15'(MOD7_M);
    c1_d45 = 13'(s0_d45[11:0]) + 13'(s0_d45[13:12]);
    c1_dl  = 17'(s0_dl[21:12]) * 17'(LED_K2) + 17'(s0_dl[11:0]);
  end

  always_ff @(posedge clk) begin
    if (move[1]) begin
      s1_d5  <= s0_d5;
      s1_d7  <= s0_d7;
      s1_q5  <= c1_p5[14:10];
      s1_q7  <= c1_p7[13:10];
      s1_d45 <= c1_d45;
      s1_dl  <= c1_dl;
      s1_lo4 <= s0_lo4;
    end
  end

  // Stage 2: residues mod 5 and 7, reciprocal products for 45 and LED_COUNT
  always_comb begin
    c2_t5  = s1_d5 - 7'(s1_q5) * 7'd5;
    c2_t7  = s1_d7 - 7'(s1_q7) * 7'd7;
    c2_p45 = 24'(s1_d45) * 24'(MOD45_M);
    c2_pl  = 41'(s1_dl) * 41'(LED_M);
  end

  always_ff @(posedge clk) begin
    if (move[2]) begin
      s2_r5  <= c2_t5[2:0];
      s2_r7  <= c2_t7[2:0];
      s2_q45 <= c2_p45[22:16];
      s2_d45 <= s1_d45;
      s2_ql  <= c2_pl[39:23];
      s2_dl  <= s1_dl;
      s2_lo4 <= s1_lo4;
    end
  end

  // Stage 3: wave phases, partial hue shift residue, chase position
  always_comb begin
    c3_t45 = s2_d45 - 13'(s2_q45) * 13'(SHIFT_MOD);
    c3_tl  = s2_dl - 17'(s2_ql) * 17'(LED_COUNT);
  end

  always_ff @(posedge clk) begin
    if (move[3]) begin
      s3_ph80   <= {s2_r5, s2_lo4};
      s3_ph28   <= {s2_r7, s2_lo4[1:0]};
      s3_r45    <= c3_t45[6:0];
      s3_active <= c3_tl[PIX_W-1:0];
    end
  end

  // Stage 4: hue shift, wave distance times span
  always_comb begin
    c4_r45    = (s3_r45 >= 7'(SHIFT_MOD)) ? s3_r45 - 7'(SHIFT_MOD) : s3_r45;
    c4_pulse  = (req[3].pattern == PAT_PULSE);
    c4_ph     = c4_pulse ? 7'(s3_ph28) : s3_ph80;
    c4_half   = c4_pulse ? 7'(PULSE_HALF) : 7'(BREATH_HALF);
    c4_rising = (c4_ph <= c4_half);
    c4_dist   = c4_rising ? c4_ph : c4_ph - c4_half;
    c4_floor  = c4_pulse ? COL_W'(PULSE_FLOOR) : COL_W'(BREATH_FLOOR);
    c4_span   = brightness - c4_floor;
  end

  always_ff @(posedge clk) begin
    if (move[4]) begin
      s4_shift  <= {c4_r45[5:0], 3'b000};
      s4_active <= s3_active;
      s4_rising <= c4_rising;
      s4_pulse  <= c4_pulse;
      s4_prod   <= 14'(c4_span) * 14'(c4_dist[5:0]);
    end
  end

  // Stage 5: divide by the half period (14 = 2 x 7, 40 = 8 x 5)
  always_comb begin
    c5_op = s4_pulse ? s4_prod[13:1] : 13'(s4_prod[13:3]);
    c5_m  = s4_pulse ? 12'(WAVE_DIV7_M) : 12'(WAVE_DIV5_M);
    c5_pq = 25'(c5_op) * 25'(c5_m);
  end

  always_ff @(posedge clk) begin
    if (move[5]) begin
      s5_shift  <= s4_shift;
      s5_active <= s4_active;
      s5_rising <= s4_rising;
      s5_pulse  <= s4_pulse;
      s5_wq     <= c5_pq[21:14];
    end
  end

  // Stage 6: wave level; brightness if not a wave or the floor reaches it
  always_comb begin
    c6_floor = s5_pulse ? COL_W'(PULSE_FLOOR) : COL_W'(BREATH_FLOOR);
    c6_wave  = (req[5].pattern == PAT_BREATH) || (req[5].pattern == PAT_PULSE);
    if (c6_wave && (brightness > c6_floor)) begin
      c6_level = s5_rising ? c6_floor + s5_wq : brightness - s5_wq;
    end else begin
      c6_level = brightness;
    end
  end

  always_ff @(posedge clk) begin
    if (move[6]) begin
      s6_ctx <= '{pattern: req[5].pattern, red: req[5].red, green: req[5].green,
                  blue: req[5].blue, level: c6_level, active: s5_active,
                  shift: s5_shift};
    end
  end

endmodule

>>> hw/rtl/lspr_pixel_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip pattern renderer - pixel sequencer
// Holds one frame's values and issues one LED job per cycle, LED 0 first,
// unless stalled; takes the next frame in the cycle that issues the last LED.
// ----------------------------------------------------------------------------
module lspr_pixel_seq import lspr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       ctx_valid,
  output logic       ctx_stall,
  input  frame_ctx_t ctx,
  output logic       item_valid,
  input  logic       item_stall,
  output pix_item_t  item
);

  logic             busy;
  logic [PIX_W-1:0] cnt;
  frame_ctx_t       held;
  logic             issue;
  logic             last;
  logic             take;

  always_comb begin
    issue     = busy && !item_stall;
    last      = (cnt == LAST_IDX);
    take      = ctx_valid && (!busy || (issue && last));
    ctx_stall = busy && !(issue && last);
  end

  // Advance the LED counter, reload on a new frame
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (take) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (issue) begin
      busy <= !last;
      cnt  <= cnt + 1'b1;
    end
  end

  // Hold the frame values while its LEDs go out
  always_ff @(posedge clk) begin
    if (take) begin
      held <= ctx;
    end
  end

  assign item_valid = busy;
  assign item       = '{ctx: held, idx: cnt, last: last};

endmodule

>>> hw/rtl/lspr_pixel_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip pattern renderer - pixel stages
// Four register stages per LED: hue and level, hue sector, products,
// scale by 1/255 into the output register.
// ----------------------------------------------------------------------------
module lspr_pixel_calc import lspr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  pix_item_t        item,
  input  logic [COL_W-1:0] brightness,
  output logic             pix_valid,
  input  logic             pix_stall,
  output pix_out_t         pix
);

  localparam int NST = 4;

  logic [NST-1:0] vld;
  logic [NST-1:0] move;

  // Stage 0
  logic             p0_rainbow;
  logic [HUE_W-1:0] p0_hue;
  logic [COL_W-1:0] p0_lv;
  logic [COL_W-1:0] p0_red, p0_green, p0_blue;
  logic [PIX_W-1:0] p0_idx;
  logic             p0_last;
  // Stage 1
  logic             p1_rainbow;
  hue_sector_t      p1_sec;
  logic [COL_W-1:0] p1_rem;
  logic [COL_W-1:0] p1_lv;
  logic [COL_W-1:0] p1_red, p1_green, p1_blue;
  logic [PIX_W-1:0] p1_idx;
  logic             p1_last;
  // Stage 2
  logic             p2_rainbow;
  hue_sector_t      p2_sec;
  logic [15:0]      p2_m0, p2_m1, p2_m2;
  logic [PIX_W-1:0] p2_idx;
  logic             p2_last;
  // Stage 3: output register
  pix_out_t         p3;

  // Combinational
  logic [HUE_W:0]   c0_sum;
  logic [15:0]      c0_b10;
  logic [COL_W-1:0] c0_lv;
  hue_sector_t      c1_sec;
  logic [HUE_W-1:0] c1_hm;
  logic [9:0]       c1_rp;
  logic [COL_W-1:0] c2_a0, c2_b0, c2_a1, c2_b1;
  logic [COL_W-1:0] c3_d0, c3_d1, c3_d2;
  logic [COL_W-1:0] c3_r, c3_g, c3_b;

  // Stage enables
  always_comb begin
    move[NST-1] = !vld[NST-1] || !pix_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      move[k] = !vld[k] || move[k+1];
    end
  end

  assign item_stall = !move[0];
  assign pix_valid  = vld[NST-1];
  assign pix        = p3;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (move[0]) begin
        vld[0] <= item_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (move[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 0: LED hue, LED level
  always_comb begin
    c0_sum = (HUE_W+1)'(item.ctx.shift) + (HUE_W+1)'(hue_offset(item.idx));
    c0_b10 = 16'(brightness) * 16'(DIV10_M);
    if (item.ctx.pattern == PAT_CHASE) begin
      c0_lv = (item.idx == item.ctx.active) ? brightness : COL_W'(c0_b10[15:11]);
    end else begin
      c0_lv = item.ctx.level;
    end
  end

  always_ff @(posedge clk) begin
    if (move[0]) begin
      p0_rainbow <= (item.ctx.pattern >= PAT_RAINBOW);
      p0_hue     <= (c0_sum >= (HUE_W+1)'(HUE_FULL)) ?
                    HUE_W'(c0_sum - (HUE_W+1)'(HUE_FULL)) : HUE_W'(c0_sum);
      p0_lv      <= c0_lv;
      p0_red     <= item.ctx.red;
      p0_green   <= item.ctx.green;
      p0_blue    <= item.ctx.blue;
      p0_idx     <= item.idx;
      p0_last    <= item.last;
    end
  end

  // Stage 1: hue sector and position within it (255/60 = 17/4)
  always_comb begin
    priority if (p0_hue < HUE_W'(HUE_SECTOR)) begin
      c1_sec = SEC_RED;
      c1_hm  = p0_hue;
    end else if (p0_hue < HUE_W'(2 * HUE_SECTOR)) begin
      c1_sec = SEC_YELLOW;
      c1_hm  = p0_hue - HUE_W'(HUE_SECTOR);
    end else if (p0_hue < HUE_W'(3 * HUE_SECTOR)) begin
      c1_sec = SEC_GREEN;
      c1_hm  = p0_hue - HUE_W'(2 * HUE_SECTOR);
    end else if (p0_hue < HUE_W'(4 * HUE_SECTOR)) begin
      c1_sec = SEC_CYAN;
      c1_hm  = p0_hue - HUE_W'(3 * HUE_SECTOR);
    end else if (p0_hue < HUE_W'(5 * HUE_SECTOR)) begin
      c1_sec = SEC_BLUE;
      c1_hm  = p0_hue - HUE_W'(4 * HUE_SECTOR);
    end else begin
      c1_sec = SEC_MAGENTA;
      c1_hm  = p0_hue - HUE_W'(5 * HUE_SECTOR);
    end
    c1_rp = 10'(c1_hm[5:0]) * 10'd17;
  end

  always_ff @(posedge clk) begin
    if (move[1]) begin
      p1_rainbow <= p0_rainbow;
      p1_sec     <= c1_sec;
      p1_rem     <= c1_rp[9:2];
      p1_lv      <= p0_lv;
      p1_red     <= p0_red;
      p1_green   <= p0_green;
      p1_blue    <= p0_blue;
      p1_idx     <= p0_idx;
      p1_last    <= p0_last;
    end
  end

  // Stage 2: colour times level, or value times falling and rising ramps
  always_comb begin
    c2_a0 = p1_rainbow ? brightness : p1_red;
    c2_b0 = p1_rainbow ? 8'd255 - p1_rem : p1_lv;
    c2_a1 = p1_rainbow ? brightness : p1_green;
    c2_b1 = p1_rainbow ? p1_rem : p1_lv;
  end

  always_ff @(posedge clk) begin
    if (move[2]) begin
      p2_rainbow <= p1_rainbow;
      p2_sec     <= p1_sec;
      p2_m0      <= 16'(c2_a0) * 16'(c2_b0);
      p2_m1      <= 16'(c2_a1) * 16'(c2_b1);
      p2_m2      <= 16'(p1_blue) * 16'(p1_lv);
      p2_idx     <= p1_idx;
      p2_last    <= p1_last;
    end
  end

  // Stage 3: scale down and place the ramps by sector
  always_comb begin
    c3_d0 = div255(p2_m0);
    c3_d1 = div255(p2_m1);
    c3_d2 = div255(p2_m2);
    if (p2_rainbow) begin
      unique case (p2_sec)
        SEC_RED:    begin c3_r = brightness; c3_g = c3_d1;      c3_b = '0;         end
        SEC_YELLOW: begin c3_r = c3_d0;      c3_g = brightness; c3_b = '0;         end
        SEC_GREEN:  begin c3_r = '0;         c3_g = brightness; c3_b = c3_d1;      end
        SEC_CYAN:   begin c3_r = '0;         c3_g = c3_d0;      c3_b = brightness; end
        SEC_BLUE:   begin c3_r = c3_d1;      c3_g = '0;         c3_b = brightness; end
        default:    begin c3_r = brightness; c3_g = '0;         c3_b = c3_d0;      end
      endcase
    end else begin
      c3_r = c3_d0;
      c3_g = c3_d1;
      c3_b = c3_d2;
    end
  end

  always_ff @(posedge clk) begin
    if (move[3]) begin
      p3 <= '{idx: p2_idx, red: c3_r, green: c3_g, blue: c3_b, last: p2_last};
    end
  end

endmodule

>>> hw/rtl/led_strip_pattern_renderer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip pattern renderer - top level
// One frame request in, LED_COUNT coloured LEDs out, the last one marked.
// ----------------------------------------------------------------------------
// Each accepted frame request yields LED_COUNT results, LED 0 first, one per
// cycle while pix_stall is low, and requests may follow one another without
// gaps; the pace is set by the pixel sequencer, which issues one LED per
// cycle unless stalled. The first LED of a request passes the 7 frame
// stages, the sequencer and 3 pixel stages before it reaches the output
// register. Brightness is written through cfg_write and cfg_data and
// resets to 128; write it only while no frame is in flight.
module led_strip_pattern_renderer_top import lspr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [COL_W-1:0]   cfg_data,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [PAT_W-1:0]   pattern,
  input  logic [COL_W-1:0]   base_red,
  input  logic [COL_W-1:0]   base_green,
  input  logic [COL_W-1:0]   base_blue,
  input  logic [FRAME_W-1:0] frame_number,
  output logic               pix_valid,
  input  logic               pix_stall,
  output logic [PIX_W-1:0]   pixel_index,
  output logic [COL_W-1:0]   out_red,
  output logic [COL_W-1:0]   out_green,
  output logic [COL_W-1:0]   out_blue,
  output logic               last_pixel
);

  logic [COL_W-1:0] brightness;
  logic             ctx_valid;
  logic             ctx_stall;
  frame_ctx_t       ctx;
  logic             item_valid;
  logic             item_stall;
  pix_item_t        item;
  pix_out_t         pix;

  // Brightness register
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= BRIGHT_RESET;
    end else if (cfg_write) begin
      brightness <= cfg_data;
    end
  end

  lspr_frame_prep u_frame (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .pattern      (pattern),
    .base_red     (base_red),
    .base_green   (base_green),
    .base_blue    (base_blue),
    .frame_number (frame_number),
    .brightness   (brightness),
    .ctx_valid    (ctx_valid),
    .ctx_stall    (ctx_stall),
    .ctx          (ctx)
  );

  lspr_pixel_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .ctx_valid  (ctx_valid),
    .ctx_stall  (ctx_stall),
    .ctx        (ctx),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item)
  );

  lspr_pixel_calc u_calc (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .brightness (brightness),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .pix        (pix)
  );

  // Unpack the output register onto the result ports
  assign pixel_index = pix.idx;
  assign out_red     = pix.red;
  assign out_green   = pix.green;
  assign out_blue    = pix.blue;
  assign last_pixel  = pix.last;

endmodule

>>> hw/rtl/lspr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip pattern renderer - port checker
// Watches the result port: LED numbering, last marking, stall hold, reset.
// ----------------------------------------------------------------------------
module lspr_checker import lspr_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               pix_valid,
  input logic               pix_stall,
  input logic [PIX_W-1:0]   pixel_index,
  input logic [COL_W-1:0]   out_red,
  input logic [COL_W-1:0]   out_green,
  input logic [COL_W-1:0]   out_blue,
  input logic               last_pixel
);

  // Last marking sits on the final LED and only there
  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    pix_valid && last_pixel |-> pixel_index == LAST_IDX)
    else $error("last_pixel on an LED other than the final one");

  a_final_is_last: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pixel_index == LAST_IDX |-> last_pixel)
    else $error("final LED without last_pixel");

  // After a taken LED that is not the last, the next one shown is its successor
  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_stall && !last_pixel |=>
      !pix_valid || pixel_index == $past(pixel_index) + 1'b1)
    else $error("LED index did not advance by one");

  // A stalled transaction holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_stall |=> pix_valid && $stable(pixel_index) &&
      $stable(out_red) && $stable(out_green) && $stable(out_blue) &&
      $stable(last_pixel))
    else $error("stalled transaction changed");

  // Reset drops the output
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !pix_valid)
    else $error("result valid right after reset");

endmodule

bind led_strip_pattern_renderer_top lspr_checker u_lspr_checker (.*);

>>> verif/led_strip_pattern_renderer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip pattern renderer - testbench
// Drives frame requests through a valid/stall channel and checks every LED
// colour that comes back against a behavioural prediction of the renderer.
// A short directed run covers every pattern, wave turning points, chase wrap
// and rainbow rotation wrap. Random phases then follow at several brightness
// settings (extremes and wave-floor cases) and idle/stall mixes, with one long
// receiver hold-off that backs up the block.
// ----------------------------------------------------------------------------
module led_strip_pattern_renderer_top_tb;
  import lspr_pkg::*;

  localparam int unsigned FULL_SAT     = 255;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          RAND_PER_SET = 19;
  localparam int          PRINT_CAP    = 40;

  typedef struct {
    logic [PAT_W-1:0]   pat;
    logic [COL_W-1:0]   red;
    logic [COL_W-1:0]   green;
    logic [COL_W-1:0]   blue;
    logic [FRAME_W-1:0] frame;
  } frame_req_t;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               cfg_write    = 1'b0;
  logic [COL_W-1:0]   cfg_data     = '0;
  logic               req_valid    = 1'b0;
  logic               req_stall;
  logic [PAT_W-1:0]   pattern      = '0;
  logic [COL_W-1:0]   base_red     = '0;
  logic [COL_W-1:0]   base_green   = '0;
  logic [COL_W-1:0]   base_blue    = '0;
  logic [FRAME_W-1:0] frame_number = '0;
  logic               pix_valid;
  logic               pix_stall    = 1'b0;
  logic [PIX_W-1:0]   pixel_index;
  logic [COL_W-1:0]   out_red;
  logic [COL_W-1:0]   out_green;
  logic [COL_W-1:0]   out_blue;
  logic               last_pixel;

  frame_req_t   frame_requests[$];
  pix_out_t     pending_leds[$];
  int unsigned  brightness_now = BRIGHT_RESET;
  int           mismatch_count = 0;
  int           sender_idle_pct = 0;
  int           recv_stall_pct = 0;
  logic         req_taken = 1'b0;
  logic         recv_holding = 1'b0;
  event         recv_hold_ev;

  led_strip_pattern_renderer_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .pattern      (pattern),
    .base_red     (base_red),
    .base_green   (base_green),
    .base_blue    (base_blue),
    .frame_number (frame_number),
    .pix_valid    (pix_valid),
    .pix_stall    (pix_stall),
    .pixel_index  (pixel_index),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .last_pixel   (last_pixel)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Colour component times level over 255, rounded down
  function automatic int unsigned scale_level(input logic [COL_W-1:0] v,
                                              input int unsigned lvl);
    return (int'(v) * (lvl & 8'hFF)) / 255;
  endfunction

  // Triangle wave from floor up to peak and back; flat at peak when the
  // floor is not below it
  function automatic int unsigned wave_level(input int unsigned frame, half,
                                             floor_lvl, peak);
    int unsigned phase, span;
    if (floor_lvl >= peak) return peak;
    phase = frame % (2 * half);
    span  = peak - floor_lvl;
    if (phase <= half) return floor_lvl + (span * phase) / half;
    return peak - (span * (phase - half)) / half;
  endfunction

  // Integer HSV to RGB at full saturation
  function automatic void hue_to_rgb(input int unsigned hue, val,
                                     output int unsigned r, g, b);
    hue_sector_t sec;
    int unsigned rem, p, q, t;
    sec = hue_sector_t'((hue / HUE_SECTOR) % 6);
    rem = ((hue % HUE_SECTOR) * 255) / HUE_SECTOR;
    p = (val * (255 - FULL_SAT)) / 255;
    q = (val * (255 - (FULL_SAT * rem) / 255)) / 255;
    t = (val * (255 - (FULL_SAT * (255 - rem)) / 255)) / 255;
    case (sec)
      SEC_RED: begin
        r = val; g = t; b = p;
      end
      SEC_YELLOW: begin
        r = q; g = val; b = p;
      end
      SEC_GREEN: begin
        r = p; g = val; b = t;
      end
      SEC_CYAN: begin
        r = p; g = q; b = val;
      end
      SEC_BLUE: begin
        r = t; g = p; b = val;
      end
      default: begin
        r = val; g = p; b = q;
      end
    endcase
  endfunction

  // Work out the colour of every LED for one accepted frame request
  function automatic void render_frame(input frame_req_t rq);
    int unsigned lvl, lv, rot, f8, active, hue, r, g, b;
    pix_out_t px;
    lvl    = brightness_now;
    f8     = rq.frame * 32'd8;
    rot    = f8 % HUE_FULL;
    active = rq.frame % LED_COUNT;
    if (rq.pat == PAT_BREATH)
      lvl = wave_level(rq.frame, BREATH_HALF, BREATH_FLOOR, brightness_now);
    else if (rq.pat == PAT_PULSE)
      lvl = wave_level(rq.frame, PULSE_HALF, PULSE_FLOOR, brightness_now);
    for (int i = 0; i < LED_COUNT; i++) begin
      if (rq.pat >= PAT_RAINBOW) begin
        hue = (rot + (i * HUE_FULL) / LED_COUNT) % HUE_FULL;
        hue_to_rgb(hue, brightness_now, r, g, b);
      end else begin
        lv = lvl;
        if (rq.pat == PAT_CHASE)
          lv = (i == active) ? brightness_now : brightness_now / 10;
        r = scale_level(rq.red, lv);
        g = scale_level(rq.green, lv);
        b = scale_level(rq.blue, lv);
      end
      px.idx   = PIX_W'(i);
      px.red   = COL_W'(r);
      px.green = COL_W'(g);
      px.blue  = COL_W'(b);
      px.last  = (i == LED_COUNT - 1);
      pending_leds.push_back(px);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic queue_frame(input logic [PAT_W-1:0] pat, input logic [COL_W-1:0] r,
                             input logic [COL_W-1:0] g, input logic [COL_W-1:0] b,
                             input logic [FRAME_W-1:0] frame);
    frame_requests.push_back('{pat, r, g, b, frame});
  endtask

  task automatic write_brightness(input logic [COL_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Hold until every request is taken and every LED has come back
  task automatic wait_for_drain();
    while (frame_requests.size() != 0 || req_valid || pending_leds.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Request driver: offer the next queued frame, hold it while stalled
  always @(negedge clk) begin : req_driver
    frame_req_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (frame_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        nxt = frame_requests.pop_front();
        req_valid    <= 1'b1;
        pattern      <= nxt.pat;
        base_red     <= nxt.red;
        base_green   <= nxt.green;
        base_blue    <= nxt.blue;
        frame_number <= nxt.frame;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Output back-pressure: random stalls plus the long hold-off
  always @(negedge clk) begin
    if (rst) pix_stall <= 1'b0;
    else pix_stall <= recv_holding || ($urandom_range(99) < recv_stall_pct);
  end

  // Long receiver hold-off, counted here in clock cycles
  always begin
    @(recv_hold_ev);
    recv_holding = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    recv_holding = 1'b0;
  end

  // Monitor: track brightness, predict accepted frames, check each LED
  always @(posedge clk) begin : led_monitor
    pix_out_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_valid && !req_stall;
      if (cfg_write) brightness_now = cfg_data;
      if (req_valid && !req_stall)
        render_frame('{pattern, base_red, base_green, base_blue, frame_number});
      if (pix_valid && !pix_stall) begin
        if (pending_leds.size() == 0) begin
          report_mismatch($sformatf("LED %0d with no frame outstanding", pixel_index));
        end else begin
          want = pending_leds.pop_front();
          if (pixel_index !== want.idx)
            report_mismatch($sformatf("pixel_index %0d, expected %0d",
                                      pixel_index, want.idx));
          if (out_red !== want.red)
            report_mismatch($sformatf("LED %0d out_red %0d, expected %0d",
                                      want.idx, out_red, want.red));
          if (out_green !== want.green)
            report_mismatch($sformatf("LED %0d out_green %0d, expected %0d",
                                      want.idx, out_green, want.green));
          if (out_blue !== want.blue)
            report_mismatch($sformatf("LED %0d out_blue %0d, expected %0d",
                                      want.idx, out_blue, want.blue));
          if (last_pixel !== want.last)
            report_mismatch($sformatf("LED %0d last_pixel %0b, expected %0b",
                                      want.idx, last_pixel, want.last));
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    logic [COL_W-1:0]   bv;
    logic [PAT_W-1:0]   pat;
    logic [FRAME_W-1:0] frm;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed frames at reset brightness, no idling
    queue_frame(PAT_SOLID, 8'd255, 8'd255, 8'd255, 32'd0);
    queue_frame(PAT_SOLID, 8'd0, 8'd0, 8'd0, 32'hFFFF_FFFF);
    queue_frame(PAT_SOLID, 8'd255, 8'd0, 8'd170, 32'd123);
    queue_frame(PAT_BREATH, 8'd255, 8'd128, 8'd1, 32'd0);
    queue_frame(PAT_BREATH, 8'd255, 8'd255, 8'd255, 32'd40);
    queue_frame(PAT_BREATH, 8'd200, 8'd100, 8'd50, 32'd41);
    queue_frame(PAT_BREATH, 8'd255, 8'd255, 8'd255, 32'd79);
    queue_frame(PAT_BREATH, 8'd17, 8'd34, 8'd68, 32'd80);
    queue_frame(PAT_PULSE, 8'd255, 8'd255, 8'd255, 32'd14);
    queue_frame(PAT_PULSE, 8'd255, 8'd200, 8'd0, 32'd15);
    queue_frame(PAT_PULSE, 8'd90, 8'd90, 8'd90, 32'd27);
    queue_frame(PAT_PULSE, 8'd1, 8'd2, 8'd3, 32'd28);
    queue_frame(PAT_CHASE, 8'd255, 8'd255, 8'd255, 32'd0);
    queue_frame(PAT_CHASE, 8'd255, 8'd64, 8'd8, 32'd15);
    queue_frame(PAT_CHASE, 8'd100, 8'd200, 8'd255, 32'hFFFF_FFFF);
    queue_frame(PAT_RAINBOW, 8'd0, 8'd0, 8'd0, 32'd0);
    queue_frame(PAT_RAINBOW + 3'd1, 8'd255, 8'd255, 8'd255, 32'd45);
    // rotation product wraps to zero
    queue_frame(PAT_RAINBOW + 3'd2, 8'd7, 8'd7, 8'd7, 32'h2000_0000);
    queue_frame(PAT_RAINBOW + 3'd3, 8'd0, 8'd255, 8'd0, 32'hFFFF_FFFF);
    // base colour must have no effect on rainbow
    queue_frame(PAT_RAINBOW, 8'd12, 8'd34, 8'd56, 32'd7);
    wait_for_drain();

    // Random phases over several brightness settings and idle mixes
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: bv = 8'd255;
        1: bv = 8'd0;
        2: bv = 8'd20;
        3: bv = 8'd16;
        4: bv = 8'd24;
        5: bv = 8'd1;
        default: bv = COL_W'($urandom_range(255));
      endcase
      write_brightness(bv);
      case (ph % 4)
        0: begin
          sender_idle_pct = 0;  recv_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 69; recv_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;  recv_stall_pct = 69;
        end
        default: begin
          sender_idle_pct = 34; recv_stall_pct = 34;
        end
      endcase
      // back up the block while the sender keeps offering
      if (ph == 4) -> recv_hold_ev;
      for (int n = 0; n < RAND_PER_SET; n++) begin
        if (n == 0) pat = PAT_BREATH;
        else if (n == 1) pat = PAT_PULSE;
        else pat = PAT_W'($urandom_range(7));
        frm = ($urandom_range(1) != 0) ? FRAME_W'($urandom) : FRAME_W'($urandom_range(200));
        queue_frame(pat, COL_W'($urandom_range(255)), COL_W'($urandom_range(255)),
                    COL_W'($urandom_range(255)), frm);
      end
      wait_for_drain();
    end

    if (pending_leds.size() != 0)
      report_mismatch($sformatf("%0d LEDs never arrived", pending_leds.size()));
    if (mismatch_count == 0) begin
      $display("PASS led_strip_pattern_renderer_top");
    end else begin
      $display("FAIL led_strip_pattern_renderer_top");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("FAIL led_strip_pattern_renderer_top");
    $finish;
  end

endmodule
